>>> sv/single_linkage_merge_engine_defines.svh
// Assertion macros for the single-linkage merge engine.
// Included by the top level; no other dependencies.
`ifndef SINGLE_LINKAGE_MERGE_ENGINE_DEFINES_SVH
`define SINGLE_LINKAGE_MERGE_ENGINE_DEFINES_SVH

// Same-cycle property, checked outside reset.
`define SLME_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define SLME_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/slme_pkg.sv
// Shared types and constants of the single-linkage merge engine.
// No dependencies.
`default_nettype none

package slme_pkg;

    localparam int NODE_W   = 11;
    localparam int POINT_W  = 10;
    localparam int WEIGHT_W = 63;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0]   left_node;
        logic [NODE_W-1:0]   right_node;
        logic [NODE_W-1:0]   node_id;
        logic [NODE_W-1:0]   merged_size;
        logic [WEIGHT_W-1:0] merge_weight;
        logic                all_joined;
    } merge_rec_t;

    typedef struct packed {
        logic busy;
        logic clearing;
    } ctrl_stat_t;

endpackage

`default_nettype wire

>>> sv/slme_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Write-to-read forwarding on a same-address collision. No dependencies.
`default_nettype none

module slme_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            // new data wins on a collision
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/slme_ctrl.sv
// Sequencer of the merge engine: clearing sweep, root walks with path
// halving, cluster info reads and merge writeback. Uses slme_pkg.
`default_nettype none

module slme_ctrl
    import slme_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int IW         = 10,
    parameter int INFO_W     = 2 * 11 + 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // config
    input  wire logic                cfg_valid,
    input  wire logic [NODE_W-1:0]   cfg_point_count,
    // edge channel payload
    input  wire logic                edge_valid,
    input  wire logic                opcode,
    input  wire logic [POINT_W-1:0]  point_a,
    input  wire logic [POINT_W-1:0]  point_b,
    input  wire logic [WEIGHT_W-1:0] edge_weight,
    output ctrl_stat_t               stat,
    // parent memory
    output logic                     par_we,
    output logic [IW-1:0]            par_waddr,
    output logic [IW-1:0]            par_wdata,
    output logic                     par_re,
    output logic [IW-1:0]            par_raddr,
    input  wire logic [IW-1:0]       par_rdata,
    // cluster info memory {size, node, minimum point}
    output logic                     inf_we,
    output logic [IW-1:0]            inf_waddr,
    output logic [INFO_W-1:0]        inf_wdata,
    output logic                     inf_re,
    output logic [IW-1:0]            inf_raddr,
    input  wire logic [INFO_W-1:0]   inf_rdata,
    // result push
    input  wire logic                out_free,
    output logic                     push,
    output merge_rec_t               rec
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_P,
        S_FIND_GP,
        S_INFO_A,
        S_INFO_B,
        S_MERGE
    } state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_POINTS - 1);

    state_t              state_reg, state_next;
    logic [IW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]   merge_count_reg, merge_count_next;
    logic [NODE_W-1:0]   point_count_reg, point_count_next;
    logic                find_b_reg, find_b_next;

    logic [IW-1:0]       x_reg, x_next;
    logic [IW-1:0]       p_reg, p_next;
    logic [IW-1:0]       b_idx_reg, b_idx_next;
    logic [IW-1:0]       ra_reg, ra_next;
    logic [IW-1:0]       rb_reg, rb_next;
    logic [INFO_W-1:0]   info_a_reg, info_a_next;
    logic [INFO_W-1:0]   info_b_reg, info_b_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;

    logic [31:0]         a_wide, b_wide, clr_wide;
    logic [IW-1:0]       a_idx, b_idx;
    logic                out_of_range;
    logic                root_found;
    logic [IW-1:0]       root;

    logic [NODE_W-1:0]   size_a, size_b, node_a, node_b;
    logic [IW-1:0]       min_a, min_b;
    logic [NODE_W-1:0]   sum_size, new_id, mc_inc;
    logic [IW-1:0]       keep_root, drop_root, new_min;

    assign a_wide   = 32'(point_a);
    assign b_wide   = 32'(point_b);
    assign clr_wide = 32'(clr_cnt_reg);
    assign a_idx    = a_wide[IW-1:0];
    assign b_idx    = b_wide[IW-1:0];

    assign out_of_range = (NODE_W'(point_a) >= point_count_reg)
                       || (NODE_W'(point_b) >= point_count_reg)
                       || (a_wide >= 32'(MAX_POINTS))
                       || (b_wide >= 32'(MAX_POINTS));

    // merge arithmetic from the two latched info words
    assign size_a = info_a_reg[INFO_W-1 -: NODE_W];
    assign size_b = info_b_reg[INFO_W-1 -: NODE_W];
    assign node_a = info_a_reg[IW +: NODE_W];
    assign node_b = info_b_reg[IW +: NODE_W];
    assign min_a  = info_a_reg[IW-1:0];
    assign min_b  = info_b_reg[IW-1:0];

    assign sum_size  = size_a + size_b;
    assign new_id    = point_count_reg + merge_count_reg;
    assign mc_inc    = merge_count_reg + NODE_W'(1);
    assign keep_root = (size_a < size_b) ? rb_reg : ra_reg;
    assign drop_root = (size_a < size_b) ? ra_reg : rb_reg;
    assign new_min   = (min_a < min_b) ? min_a : min_b;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        merge_count_next = merge_count_reg;
        point_count_next = point_count_reg;
        find_b_next      = find_b_reg;
        x_next           = x_reg;
        p_next           = p_reg;
        b_idx_next       = b_idx_reg;
        ra_next          = ra_reg;
        rb_next          = rb_reg;
        info_a_next      = info_a_reg;
        info_b_next      = info_b_reg;
        weight_next      = weight_reg;

        par_we    = 1'b0;
        par_waddr = x_reg;
        par_wdata = par_rdata;
        par_re    = 1'b0;
        par_raddr = x_reg;
        inf_we    = 1'b0;
        inf_waddr = keep_root;
        inf_wdata = {sum_size, new_id, new_min};
        inf_re    = 1'b0;
        inf_raddr = ra_reg;
        push      = 1'b0;
        root_found = 1'b0;
        root       = x_reg;

        rec.left_node    = (min_a > min_b) ? node_b : node_a;
        rec.right_node   = (min_a > min_b) ? node_a : node_b;
        rec.node_id      = new_id;
        rec.merged_size  = sum_size;
        rec.merge_weight = weight_reg;
        rec.all_joined   = (mc_inc == (point_count_reg - NODE_W'(1)))
                        && (point_count_reg != '0);

        if (cfg_valid)
        begin
            point_count_next = cfg_point_count;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                par_we    = 1'b1;
                par_waddr = clr_cnt_reg;
                par_wdata = clr_cnt_reg;
                inf_we    = 1'b1;
                inf_waddr = clr_cnt_reg;
                inf_wdata = {NODE_W'(1), clr_wide[NODE_W-1:0], clr_cnt_reg};
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IW'(1);
                end
            end

            S_IDLE:
            begin
                if (edge_valid)
                begin
                    weight_next = edge_weight;
                    b_idx_next  = b_idx;
                    x_next      = a_idx;
                    find_b_next = 1'b0;
                    if (opcode == OP_CLEAR)
                    begin
                        state_next       = S_CLEAR;
                        clr_cnt_next     = '0;
                        merge_count_next = '0;
                    end
                    else if (!out_of_range)
                    begin
                        par_re     = 1'b1;
                        par_raddr  = a_idx;
                        state_next = S_FIND_P;
                    end
                end
            end

            S_FIND_P:
            begin
                if (par_rdata == x_reg)
                begin
                    root_found = 1'b1;
                    root       = x_reg;
                end
                else
                begin
                    p_next     = par_rdata;
                    par_re     = 1'b1;
                    par_raddr  = par_rdata;
                    state_next = S_FIND_GP;
                end
            end

            S_FIND_GP:
            begin
                if (par_rdata == p_reg)
                begin
                    // parent is a root
                    root_found = 1'b1;
                    root       = p_reg;
                end
                else
                begin
                    // halve: link x to its grandparent and step there
                    par_we     = 1'b1;
                    par_waddr  = x_reg;
                    par_wdata  = par_rdata;
                    x_next     = par_rdata;
                    par_re     = 1'b1;
                    par_raddr  = par_rdata;
                    state_next = S_FIND_P;
                end
            end

            S_INFO_A:
            begin
                info_a_next = inf_rdata;
                inf_re      = 1'b1;
                inf_raddr   = rb_reg;
                state_next  = S_INFO_B;
            end

            S_INFO_B:
            begin
                info_b_next = inf_rdata;
                state_next  = S_MERGE;
            end

            S_MERGE:
            begin
                if (out_free)
                begin
                    par_we           = 1'b1;
                    par_waddr        = drop_root;
                    par_wdata        = keep_root;
                    inf_we           = 1'b1;
                    inf_waddr        = keep_root;
                    push             = 1'b1;
                    merge_count_next = mc_inc;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (root_found)
        begin
            if (!find_b_reg)
            begin
                ra_next     = root;
                find_b_next = 1'b1;
                x_next      = b_idx_reg;
                par_re      = 1'b1;
                par_raddr   = b_idx_reg;
                state_next  = S_FIND_P;
            end
            else if (root == ra_reg)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                rb_next    = root;
                inf_re     = 1'b1;
                inf_raddr  = ra_reg;
                state_next = S_INFO_A;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            merge_count_reg <= '0;
            point_count_reg <= '0;
            find_b_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            merge_count_reg <= merge_count_next;
            point_count_reg <= point_count_next;
            find_b_reg      <= find_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        p_reg      <= p_next;
        b_idx_reg  <= b_idx_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        info_a_reg <= info_a_next;
        info_b_reg <= info_b_next;
        weight_reg <= weight_next;
    end

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.clearing = (state_reg == S_CLEAR);

endmodule

`default_nettype wire

>>> sv/slme_out.sv
// Output register of the merge engine: holds one merge record until the
// consumer takes it. Uses slme_pkg.
`default_nettype none

module slme_out
    import slme_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire merge_rec_t rec_in,
    output logic            free,
    input  wire logic       merge_stall,
    output logic            merge_valid,
    output merge_rec_t      rec_out
);

    logic       valid_reg, valid_next;
    merge_rec_t rec_reg;

    assign free = !valid_reg || !merge_stall;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!merge_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_reg <= rec_in;
        end
    end

    assign merge_valid = valid_reg;
    assign rec_out     = rec_reg;

endmodule

`default_nettype wire

>>> sv/single_linkage_merge_engine.sv
// Top level of the single-linkage merge engine: parent and cluster-info
// memories, sequencer and output register. Uses slme_pkg and the defines header.
//
// Channel   Direction  Handshake            Payload
// edge      in         edge_valid/stall     opcode, point_a, point_b, edge_weight
// merge     out        merge_valid/stall    left_node, right_node, node_id, merged_size,
//                                           merge_weight, all_joined
// cfg       in         cfg_valid/ready      cfg_point_count
//
// An edge is taken while the sequencer is idle. Each of the two root walks then alternates
// parent and grandparent reads, halving the path as it goes, and the two info reads and the
// writeback follow. The walks share the single read port of the parent memory, and
// out-of-range edges are dropped. After reset and after a clear opcode a sweep writes every
// entry of both memories, with edge_stall high; cfg writes go on. A waiting result stalls only
// the writeback; the record register frees on the edge the consumer takes its transfer.
`default_nettype none
`include "single_linkage_merge_engine_defines.svh"

module single_linkage_merge_engine
    import slme_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [NODE_W-1:0]   cfg_point_count,
    // edge input
    input  wire logic                edge_valid,
    output logic                     edge_stall,
    input  wire logic                opcode,
    input  wire logic [POINT_W-1:0]  point_a,
    input  wire logic [POINT_W-1:0]  point_b,
    input  wire logic [WEIGHT_W-1:0] edge_weight,
    // merge output
    output logic                     merge_valid,
    input  wire logic                merge_stall,
    output logic [NODE_W-1:0]        left_node,
    output logic [NODE_W-1:0]        right_node,
    output logic [NODE_W-1:0]        node_id,
    output logic [NODE_W-1:0]        merged_size,
    output logic [WEIGHT_W-1:0]      merge_weight,
    output logic                     all_joined
);

    // index width of the stores; the info word packs size, node id, minimum point
    localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int INFO_W = 2 * NODE_W + IW;

    ctrl_stat_t         stat;
    logic               par_we, par_re, inf_we, inf_re;
    logic [IW-1:0]      par_waddr, par_wdata, par_raddr, par_rdata;
    logic [IW-1:0]      inf_waddr, inf_raddr;
    logic [INFO_W-1:0]  inf_wdata, inf_rdata;
    logic               out_free, push;
    merge_rec_t         rec_new, rec_q;

    // register writes are always taken
    assign cfg_ready  = 1'b1;
    // edges are taken only while the sequencer sits idle
    assign edge_stall = stat.busy;

    // parent links: one entry per point, a root points at itself
    slme_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (IW),
        .AW    (IW)
    ) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    // per-root cluster info, valid only at roots
    slme_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (INFO_W),
        .AW    (IW)
    ) u_info_ram (
        .clk   (clk),
        .we    (inf_we),
        .waddr (inf_waddr),
        .wdata (inf_wdata),
        .re    (inf_re),
        .raddr (inf_raddr),
        .rdata (inf_rdata)
    );

    slme_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW),
        .INFO_W     (INFO_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_point_count (cfg_point_count),
        .edge_valid      (edge_valid),
        .opcode          (opcode),
        .point_a         (point_a),
        .point_b         (point_b),
        .edge_weight     (edge_weight),
        .stat            (stat),
        .par_we          (par_we),
        .par_waddr       (par_waddr),
        .par_wdata       (par_wdata),
        .par_re          (par_re),
        .par_raddr       (par_raddr),
        .par_rdata       (par_rdata),
        .inf_we          (inf_we),
        .inf_waddr       (inf_waddr),
        .inf_wdata       (inf_wdata),
        .inf_re          (inf_re),
        .inf_raddr       (inf_raddr),
        .inf_rdata       (inf_rdata),
        .out_free        (out_free),
        .push            (push),
        .rec             (rec_new)
    );

    slme_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .rec_in      (rec_new),
        .free        (out_free),
        .merge_stall (merge_stall),
        .merge_valid (merge_valid),
        .rec_out     (rec_q)
    );

    assign left_node    = rec_q.left_node;
    assign right_node   = rec_q.right_node;
    assign node_id      = rec_q.node_id;
    assign merged_size  = rec_q.merged_size;
    assign merge_weight = rec_q.merge_weight;
    assign all_joined   = rec_q.all_joined;

    // no edge may slip in during a sweep
    `SLME_ASSERT(a_clear_blocks_edges, clk, rst_n, !stat.clearing || edge_stall, "edge taken during clear sweep")
    // writeback must never overwrite a record still waiting
    `SLME_ASSERT(a_push_into_free, clk, rst_n, !push || out_free, "merge record overwritten")
    // a pushed record shows up on the next cycle
    `SLME_ASSERT_NEXT(a_push_shows, clk, rst_n, push, merge_valid, "pushed record not presented")
    // every merge joins at least two points
    `SLME_ASSERT(a_size_min, clk, rst_n, !merge_valid || (merged_size >= 11'd2), "merged size below two")

endmodule

`default_nettype wire
